[hw/rtl/spq_pkg.sv]
// ============================================================================
// spq_pkg
// Types and codes shared by the sorted priority queue cells and top level.
// ============================================================================
package spq_pkg;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] element;
        logic signed [31:0] priority_req;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [4:0]         count;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] element;
        logic signed [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic               enq;
        logic               deq;
        logic signed [31:0] key;
    } t_cell_ctrl;

    typedef struct packed {
        logic greater;
        logic open;
    } t_cell_flags;

endpackage

[hw/rtl/spq_cell.sv]
// ============================================================================
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the request
// key, and loads from the new entry or a neighbor on enqueue or dequeue.
// ============================================================================
module spq_cell (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctrl       i_ctrl,
    input  spq_pkg::t_entry           i_new,
    input  spq_pkg::t_entry           i_left,
    input  spq_pkg::t_entry           i_right,
    input  spq_pkg::t_cell_flags      i_left_flags,
    input  logic                      i_occ,
    output spq_pkg::t_entry           o_entry,
    output spq_pkg::t_cell_flags      o_flags
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;
    logic            greater;

    assign greater         = i_occ && (r_entry.prio > i_ctrl.key);
    assign o_flags.greater = greater;
    assign o_flags.open    = greater || !i_occ;
    assign o_entry         = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_left_flags.greater) begin
                n_entry = i_left;
            end else if (o_flags.open && !i_left_flags.open) begin
                n_entry = i_new;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

[hw/rtl/sorted_priority_queue_top.sv]
// ============================================================================
// sorted_priority_queue_top
// Priority queue kept sorted in a chain of cells; ties leave in FIFO order.
//
// Request channel: a request (enqueue, dequeue or peek) is taken on a clock
// edge where start is high and busy is low. busy is always low, so one
// request can be taken every cycle.
// Result channel: one result per request, shown on o_rsp for exactly one
// cycle with o_done high, in the cycle after the request is taken. The
// receiver cannot hold results off.
// Throughput is 1 request per cycle: every cell compares its priority
// with the key and shifts in parallel in the same cycle.
// Configuration: i_cfg_data writes the capacity when i_cfg_valid is high;
// o_cfg_ready is always high. Capacity 0 acts as 1, above DEPTH as DEPTH.
// Reset (i_rst_n low, synchronous) empties the queue and sets capacity to
// 16; no clearing pass is needed.
// ============================================================================
module sorted_priority_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  spq_pkg::t_req i_req,
    output logic          o_done,
    output spq_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [4:0]    i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = CW + 5;

    logic [4:0]    r_cap;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_done;
    spq_pkg::t_rsp r_rsp;
    spq_pkg::t_rsp n_rsp;

    logic [LW-1:0] cap_w;
    logic [LW-1:0] limit;
    logic [LW-1:0] count_w;
    logic          full;
    logic          empty;
    logic          accept;

    spq_pkg::t_cell_ctrl  ctrl;
    spq_pkg::t_entry      new_entry;
    spq_pkg::t_entry      entries [DEPTH];
    spq_pkg::t_cell_flags flags   [DEPTH];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign cap_w   = {{CW{1'b0}}, r_cap};
    assign count_w = {5'd0, r_count};
    always_comb begin
        if (cap_w == '0) begin
            limit = LW'(1);
        end else if (cap_w > LW'(DEPTH)) begin
            limit = LW'(DEPTH);
        end else begin
            limit = cap_w;
        end
    end
    assign full  = count_w >= limit;
    assign empty = r_count == '0;

    assign ctrl.enq = accept && (i_req.op == spq_pkg::OP_ENQ) && !full;
    assign ctrl.deq = accept && (i_req.op == spq_pkg::OP_DEQ) && !empty;
    assign ctrl.key = i_req.priority_req;
    assign new_entry.element = i_req.element;
    assign new_entry.prio    = i_req.priority_req;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_pkg::t_entry      left;
        spq_pkg::t_entry      right;
        spq_pkg::t_cell_flags left_flags;

        if (i == 0) begin : g_first
            assign left       = new_entry;
            assign left_flags = '0;
        end else begin : g_mid
            assign left       = entries[i-1];
            assign left_flags = flags[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right = entries[i];
        end else begin : g_inner
            assign right = entries[i+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_new        (new_entry),
            .i_left       (left),
            .i_right      (right),
            .i_left_flags (left_flags),
            .i_occ        (r_count > CW'(i)),
            .o_entry      (entries[i]),
            .o_flags      (flags[i])
        );
    end

    always_comb begin
        logic [LW-1:0] cnt_ext;
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
        cnt_ext      = {5'd0, n_count};
        n_rsp.value  = '0;
        n_rsp.status = spq_pkg::ST_OK;
        n_rsp.count  = cnt_ext[4:0];
        case (i_req.op)
            spq_pkg::OP_ENQ: begin
                if (full) begin
                    n_rsp.status = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::OP_DEQ, spq_pkg::OP_PEEK: begin
                if (empty) begin
                    n_rsp.value  = spq_pkg::EMPTY_VALUE;
                    n_rsp.status = spq_pkg::ST_EMPTY;
                end else begin
                    n_rsp.value = entries[0].element;
                end
            end
            default: begin
                n_rsp.value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 5'd16;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_count <= n_count;
            end
            r_done <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
